// ----- sv/gtl_pkg.sv -----
// Package for the graph triangle lister.
// Holds sizes, opcode and status codes, controller states and the
// command and status structs shared by the controller and the datapath.
package gtl_pkg;

  // Graph size and field widths.
  localparam int MAX_NODES = 8;
  localparam int NODE_W    = 3;
  localparam int ROW_W     = 1 << NODE_W;
  localparam int CNT_W     = 4;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 4;
  localparam int IN_W      = 8;
  localparam int OUT_W     = 16;

  // Input opcodes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_SCAN,
    S_FLUSH
  } gtl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_a;
    logic load_s;
    logic step_c;
    logic next_s;
    logic take_hit;
    logic emit_single;
    logic emit_final;
  } gtl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic list_ok;
    logic a_last;
    logic slot_free;
    logic hit;
    logic c_end;
    logic s_end;
    logic pend_valid;
  } gtl_sts_t;

endpackage

// ----- sv/gtl_ctrl.sv -----
// Controller state machine of the graph triangle lister.
// Depends on gtl_pkg for the state type and the command/status structs.
module gtl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gtl_pkg::gtl_sts_t sts,
  output gtl_pkg::gtl_cmd_t cmd
);

  gtl_pkg::gtl_state_t state_r, state_nxt;
  logic                stall;

  // A hit that would push out a pending cycle waits for a free output slot.
  assign stall = sts.hit && sts.pend_valid && !sts.slot_free;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gtl_pkg::S_IDLE: begin
        if (in_valid) state_nxt = gtl_pkg::S_EXEC;
      end
      gtl_pkg::S_EXEC: begin
        if (sts.list_ok) begin
          state_nxt = sts.a_last ? gtl_pkg::S_FLUSH : gtl_pkg::S_LOAD;
        end else if (sts.slot_free) begin
          state_nxt = gtl_pkg::S_IDLE;
        end
      end
      gtl_pkg::S_LOAD: begin
        state_nxt = gtl_pkg::S_SCAN;
      end
      gtl_pkg::S_SCAN: begin
        if (!stall && sts.c_end) begin
          state_nxt = sts.s_end ? gtl_pkg::S_FLUSH : gtl_pkg::S_LOAD;
        end
      end
      gtl_pkg::S_FLUSH: begin
        if (sts.slot_free) state_nxt = gtl_pkg::S_IDLE;
      end
      default: state_nxt = gtl_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      gtl_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      gtl_pkg::S_EXEC: begin
        cmd.load_a      = sts.list_ok;
        cmd.emit_single = !sts.list_ok && sts.slot_free;
      end
      gtl_pkg::S_LOAD: begin
        cmd.load_s = 1'b1;
      end
      gtl_pkg::S_SCAN: begin
        if (!stall) begin
          cmd.take_hit = sts.hit;
          cmd.step_c   = !sts.c_end;
          cmd.next_s   = sts.c_end && !sts.s_end;
        end
      end
      gtl_pkg::S_FLUSH: begin
        cmd.emit_final = sts.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- sv/gtl_datapath.sv -----
// Datapath of the graph triangle lister: adjacency rows, configuration,
// scan counters, the pending cycle and the output register.
// Depends on gtl_pkg for sizes, codes and the command/status structs.
module gtl_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [gtl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gtl_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [gtl_pkg::IN_W-1:0]       in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [gtl_pkg::OUT_W-1:0]      out_tdata,
  output logic                           out_tlast,
  input  gtl_pkg::gtl_cmd_t              cmd,
  output gtl_pkg::gtl_sts_t              sts
);

  localparam logic [gtl_pkg::NODE_W-1:0] LAST_NODE = gtl_pkg::NODE_W'(gtl_pkg::MAX_NODES - 1);
  localparam logic [gtl_pkg::CNT_W-1:0]  MAX_CNT   = gtl_pkg::CNT_W'(gtl_pkg::MAX_NODES);

  // Adjacency rows and configuration.
  logic [gtl_pkg::ROW_W-1:0]  adj_r [gtl_pkg::MAX_NODES];
  logic                       directed_r;
  logic [gtl_pkg::CNT_W-1:0]  node_count_r;

  // Captured transaction.
  logic [gtl_pkg::OP_W-1:0]   op_r;
  logic [gtl_pkg::NODE_W-1:0] a_r, b_r;

  // Scan state.
  logic [gtl_pkg::ROW_W-1:0]  row_a_r, row_s_r, col_a_r;
  logic [gtl_pkg::NODE_W-1:0] s_r, c_r;
  logic                       pend_valid_r;
  logic [gtl_pkg::NODE_W-1:0] pend_s_r, pend_c_r;

  // Output register.
  logic                       out_valid_r;
  logic [gtl_pkg::STAT_W-1:0] out_status_r;
  logic                       out_found_r;
  logic [gtl_pkg::NODE_W-1:0] out_n1_r, out_n2_r, out_n3_r;
  logic                       out_last_r;

  logic [gtl_pkg::CNT_W-1:0]  n_eff;
  logic                       a_ok, b_ok, s_ok, c_ok;
  logic [gtl_pkg::ROW_W-1:0]  rd_row, col_a;
  logic                       is_edge_op, edge_ok, edge_present;
  logic [gtl_pkg::STAT_W-1:0] single_status;
  logic                       do_write, hit, slot_free, out_load;

  // Effective node count and range checks.
  assign n_eff = (node_count_r > MAX_CNT) ? MAX_CNT : node_count_r;
  assign a_ok  = {1'b0, a_r} < n_eff;
  assign b_ok  = {1'b0, b_r} < n_eff;
  assign s_ok  = {1'b0, s_r} < n_eff;
  assign c_ok  = {1'b0, c_r} < n_eff;

  // Single read address: node a while executing, node s while loading a row.
  always_comb begin
    logic [gtl_pkg::NODE_W-1:0] rd_addr;
    rd_addr = cmd.load_s ? s_r : a_r;
    rd_row  = '0;
    if (rd_addr <= LAST_NODE) rd_row = adj_r[rd_addr];
  end

  // Column a of the matrix: which nodes have an edge into node a.
  always_comb begin
    col_a = '0;
    for (int i = 0; i < gtl_pkg::MAX_NODES; i++) begin
      col_a[i] = adj_r[i][a_r];
    end
  end

  // Edge command checks and the single-result status.
  assign is_edge_op   = (op_r == gtl_pkg::OP_INSERT) || (op_r == gtl_pkg::OP_DELETE);
  assign edge_ok      = a_ok && b_ok && (a_r != b_r);
  assign edge_present = rd_row[b_r];

  always_comb begin
    single_status = gtl_pkg::ST_REJECT;
    if (is_edge_op && edge_ok) begin
      if (op_r == gtl_pkg::OP_DELETE && !edge_present) begin
        single_status = gtl_pkg::ST_ABSENT;
      end else begin
        single_status = gtl_pkg::ST_DONE;
      end
    end
  end

  assign do_write = cmd.emit_single && is_edge_op && (single_status == gtl_pkg::ST_DONE);

  // Cycle test for the current (s, c) pair.
  always_comb begin
    logic close;
    if (directed_r) begin
      close = row_s_r[c_r] && col_a_r[c_r];
    end else begin
      close = (c_r > s_r) && row_a_r[c_r] && row_s_r[c_r];
    end
    hit = row_a_r[s_r] && s_ok && c_ok && (c_r != s_r) && close;
  end

  assign slot_free = !out_valid_r || out_tready;
  assign out_load  = cmd.emit_single || cmd.emit_final || (cmd.take_hit && pend_valid_r);

  // Status to the controller.
  always_comb begin
    sts            = '0;
    sts.list_ok    = (op_r == gtl_pkg::OP_LIST) && a_ok;
    sts.a_last     = (a_r == LAST_NODE);
    sts.slot_free  = slot_free;
    sts.hit        = hit;
    sts.c_end      = (c_r == LAST_NODE);
    sts.s_end      = (s_r == LAST_NODE);
    sts.pend_valid = pend_valid_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      directed_r   <= 1'b0;
      node_count_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gtl_pkg::CFG_DIRECTED:   directed_r   <= cfg_wdata[0];
        gtl_pkg::CFG_NODE_COUNT: node_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Adjacency rows: each row updates on its own index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gtl_pkg::MAX_NODES; i++) adj_r[i] <= '0;
    end else if (do_write) begin
      for (int i = 0; i < gtl_pkg::MAX_NODES; i++) begin
        if (gtl_pkg::NODE_W'(i) == a_r) begin
          adj_r[i][b_r] <= (op_r == gtl_pkg::OP_INSERT);
        end
        if (!directed_r && gtl_pkg::NODE_W'(i) == b_r) begin
          adj_r[i][a_r] <= (op_r == gtl_pkg::OP_INSERT);
        end
      end
    end
  end

  // Transaction capture and scan registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_tdata[1:0];
      a_r  <= in_tdata[4:2];
      b_r  <= in_tdata[7:5];
    end
    if (cmd.load_a) begin
      row_a_r <= rd_row;
      col_a_r <= col_a;
      s_r     <= a_r + 1'b1;
    end else if (cmd.next_s) begin
      s_r <= s_r + 1'b1;
    end
    if (cmd.load_s) begin
      row_s_r <= rd_row;
      c_r     <= a_r + 1'b1;
    end else if (cmd.step_c) begin
      c_r <= c_r + 1'b1;
    end
    if (cmd.take_hit) begin
      pend_s_r <= s_r;
      pend_c_r <= c_r;
    end
  end

  // Pending cycle flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.load_a || cmd.emit_final) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.take_hit) begin
      pend_valid_r <= 1'b1;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      out_status_r <= single_status;
      out_found_r  <= 1'b0;
      out_n1_r     <= '0;
      out_n2_r     <= '0;
      out_n3_r     <= '0;
      out_last_r   <= 1'b1;
    end else if (out_load) begin
      out_status_r <= gtl_pkg::ST_DONE;
      out_found_r  <= pend_valid_r;
      out_n1_r     <= pend_valid_r ? a_r : '0;
      out_n2_r     <= pend_valid_r ? pend_s_r : '0;
      out_n3_r     <= pend_valid_r ? pend_c_r : '0;
      out_last_r   <= cmd.emit_final;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_n3_r, out_n2_r, out_n1_r, out_found_r, out_status_r};

  // A result is loaded only into a free output slot.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> slot_free)
    else $error("result loaded over an undelivered result");

  // The final result of a listing carries the last mark.
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_final |=> (out_valid_r && out_tlast))
    else $error("final listing result lacks last mark");

  // A cycle displaced by a newer hit goes out as a non-final found result.
  a_displaced: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_hit && pend_valid_r) |=> (out_valid_r && out_found_r && !out_tlast))
    else $error("displaced cycle not emitted correctly");

endmodule

// ----- sv/graph_triangle_lister.sv -----
// Top level of the graph triangle lister.
// Depends on gtl_pkg, gtl_ctrl and gtl_datapath.
//
// Keeps an adjacency bit matrix of up to eight nodes and takes one
// transaction at a time. An insert, delete or rejected command passes through
// the execute state, where its single result enters the output register once
// the output slot is free. A listing from node a loads one adjacency row per
// second node and tests one third node per cycle while no hit waits for a free
// output slot. Results leave through an output register, so the next
// transaction is taken while the last result is still waiting to be read.
module graph_triangle_lister (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_wr_en,
  input  logic [gtl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gtl_pkg::CFG_W-1:0]     cfg_wdata,
  // Command stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0: opcode[1:0], node_a[4:2], node_b[7:5].
  input  logic [gtl_pkg::IN_W-1:0]      in_tdata,
  // Result stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // Fields from bit 0: status[1:0], found[2], first_node[5:3],
  // second_node[8:6], third_node[11:9], zero fill[15:12].
  output logic [gtl_pkg::OUT_W-1:0]     out_tdata,
  output logic                          out_tlast
);

  gtl_pkg::gtl_cmd_t cmd;
  gtl_pkg::gtl_sts_t sts;

  // Sequencer.
  gtl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Matrix, scan counters and output register.
  gtl_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
